// ===== rtl/core/fmtsp_pkg.sv =====
`default_nettype none
package fmtsp_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // port numbers
  typedef enum logic [1:0] {
    PORT_ADDR     = 2'd0,
    PORT_DATA     = 2'd1,
    PORT_EXT_ADDR = 2'd2
  } port_e;

  // chip register numbers (9 bit, extended bank sets bit 8)
  localparam logic [8:0] REG_PRESET_ONE = 9'h002;
  localparam logic [8:0] REG_PRESET_TWO = 9'h003;
  localparam logic [8:0] REG_CONTROL    = 9'h004;

  // control register bits
  localparam int unsigned CTRL_STOP_BIT  = 7;
  localparam int unsigned CTRL_MASK1_BIT = 6;
  localparam int unsigned CTRL_MASK2_BIT = 5;
  localparam int unsigned CTRL_ON2_BIT   = 1;
  localparam int unsigned CTRL_ON1_BIT   = 0;

  // status byte codes
  localparam logic [7:0] STATUS_ANY = 8'h80;
  localparam logic [7:0] STATUS_T1  = 8'h40;
  localparam logic [7:0] STATUS_T2  = 8'h20;
  localparam logic [7:0] STATUS_EXT = 8'hFF;

  // full timer count
  localparam logic [8:0] COUNT_FULL = 9'h100;

  // configuration register indexes and reset values
  localparam logic       CFG_IDX_T1 = 1'b0;
  localparam logic       CFG_IDX_T2 = 1'b1;
  localparam logic [15:0] T1_PERIOD_RST = 16'd80;
  localparam logic [15:0] T2_PERIOD_RST = 16'd320;

  typedef struct packed {
    logic [15:0] t1_period;
    logic [15:0] t2_period;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    port_e       port;
    logic [7:0]  value;
    logic [19:0] elapsed_us;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/core/fm_chip_timer_status_port_top.sv =====
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o | kind_i port_i value_i elapsed_us_i
// out     | output    | out_valid_o / out_stall_i | read_data_o
// cfg     | input     | psel penable pwrite pready | paddr pwdata prdata
//
// one item per cycle unless a read waits on a stalled result: an item is taken into
// the input register, then steps the timer state from that register; a read result
// is then captured in the result register, which drives out_valid_o
// the per-item step is two 9x16 multiplies (one per timer), time-width adds and compares
// reset clears the valid flags and timer state, periods return to 80 and 320 us
// a held result stalls the input only while a read waits in the input register
`default_nettype none
module fm_chip_timer_status_port_top #(
  parameter int unsigned TIME_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  port_i,
  input  logic [7:0]  value_i,
  input  logic [19:0] elapsed_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fmtsp_pkg::*;

  cfg_t       cfg;
  item_t      item_q;
  logic       s1_valid_q;
  logic       out_valid_q;
  logic [7:0] read_data_q;
  logic [7:0] rdata;
  logic       out_free;
  logic       exec;
  logic       in_accept;

  fmtsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fmtsp_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .exec_i  (exec),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .rdata_o (rdata)
  );

  // flow control: only a read needs the output register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exec       = s1_valid_q && ((item_q.kind != KIND_READ) || out_free);
  assign in_stall_o = s1_valid_q && !exec;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (exec) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.kind       <= kind_e'(kind_i);
      item_q.port       <= port_e'(port_i);
      item_q.value      <= value_i;
      item_q.elapsed_us <= elapsed_us_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec && item_q.kind == KIND_READ) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && item_q.kind == KIND_READ) begin
      read_data_q <= rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

endmodule
`default_nettype wire

// ===== rtl/core/fmtsp_cfg.sv =====
`default_nettype none
module fmtsp_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output fmtsp_pkg::cfg_t   cfg_o
);
  import fmtsp_pkg::*;

  logic [15:0] t1_period_q;
  logic [15:0] t2_period_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // period registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_period_q <= T1_PERIOD_RST;
      t2_period_q <= T2_PERIOD_RST;
    end else if (wr_en) begin
      case (paddr[2])
        CFG_IDX_T1: t1_period_q <= pwdata[15:0];
        CFG_IDX_T2: t2_period_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      CFG_IDX_T1: prdata = {16'd0, t1_period_q};
      CFG_IDX_T2: prdata = {16'd0, t2_period_q};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o.t1_period = t1_period_q;
  assign cfg_o.t2_period = t2_period_q;

endmodule
`default_nettype wire

// ===== rtl/core/fmtsp_core.sv =====
`default_nettype none
module fmtsp_core #(
  parameter int unsigned TIME_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              exec_i,
  input  fmtsp_pkg::item_t  item_i,
  input  fmtsp_pkg::cfg_t   cfg_i,
  output logic [7:0]        rdata_o
);
  import fmtsp_pkg::*;

  logic [TIME_WIDTH-1:0] run_q, run_d;
  logic [TIME_WIDTH-1:0] dl1_q, dl1_d;
  logic [TIME_WIDTH-1:0] dl2_q, dl2_d;
  logic [8:0]            sel_q, sel_d;
  logic [7:0]            pre1_q, pre1_d;
  logic [7:0]            pre2_q, pre2_d;
  logic                  on1_q, on1_d;
  logic                  on2_q, on2_d;

  logic [7:0]            pre1_src, pre2_src;
  logic [8:0]            cnt1, cnt2;
  logic [24:0]           prod1, prod2;
  logic [TIME_WIDTH-1:0] new_dl1, new_dl2;
  logic                  data_wr;
  logic [7:0]            status;

  // timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      dl1_q  <= '0;
      dl2_q  <= '0;
      sel_q  <= '0;
      pre1_q <= '0;
      pre2_q <= '0;
      on1_q  <= 1'b0;
      on2_q  <= 1'b0;
    end else begin
      run_q  <= run_d;
      dl1_q  <= dl1_d;
      dl2_q  <= dl2_d;
      sel_q  <= sel_d;
      pre1_q <= pre1_d;
      pre2_q <= pre2_d;
      on1_q  <= on1_d;
      on2_q  <= on2_d;
    end
  end

  // deadline candidates, a preset write uses the byte being written
  assign data_wr  = exec_i && (item_i.kind == KIND_WRITE) && (item_i.port == PORT_DATA);
  assign pre1_src = (data_wr && sel_q == REG_PRESET_ONE) ? item_i.value : pre1_q;
  assign pre2_src = (data_wr && sel_q == REG_PRESET_TWO) ? item_i.value : pre2_q;
  assign cnt1     = COUNT_FULL - {1'b0, pre1_src};
  assign cnt2     = COUNT_FULL - {1'b0, pre2_src};
  assign prod1    = 25'(cnt1) * 25'(cfg_i.t1_period);
  assign prod2    = 25'(cnt2) * 25'(cfg_i.t2_period);
  assign new_dl1  = run_q + TIME_WIDTH'(prod1);
  assign new_dl2  = run_q + TIME_WIDTH'(prod2);

  // one item step
  always_comb begin
    run_d  = run_q;
    dl1_d  = dl1_q;
    dl2_d  = dl2_q;
    sel_d  = sel_q;
    pre1_d = pre1_q;
    pre2_d = pre2_q;
    on1_d  = on1_q;
    on2_d  = on2_q;
    if (exec_i) begin
      case (item_i.kind)
        KIND_TICK: run_d = run_q + TIME_WIDTH'(item_i.elapsed_us);
        KIND_WRITE: begin
          case (item_i.port)
            PORT_ADDR:     sel_d = {1'b0, item_i.value};
            PORT_EXT_ADDR: sel_d = {1'b1, item_i.value};
            PORT_DATA: begin
              case (sel_q)
                REG_PRESET_ONE: begin
                  pre1_d = item_i.value;
                  if (on1_q) dl1_d = new_dl1;
                end
                REG_PRESET_TWO: begin
                  pre2_d = item_i.value;
                  if (on2_q) dl2_d = new_dl2;
                end
                REG_CONTROL: begin
                  if (item_i.value[CTRL_STOP_BIT]) begin
                    on1_d = 1'b0;
                    on2_d = 1'b0;
                  end else begin
                    if (!item_i.value[CTRL_MASK1_BIT]) begin
                      on1_d = item_i.value[CTRL_ON1_BIT];
                      if (item_i.value[CTRL_ON1_BIT]) dl1_d = new_dl1;
                    end
                    if (!item_i.value[CTRL_MASK2_BIT]) begin
                      on2_d = item_i.value[CTRL_ON2_BIT];
                      if (item_i.value[CTRL_ON2_BIT]) dl2_d = new_dl2;
                    end
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // status byte from current state
  always_comb begin
    status = 8'd0;
    if (on1_q && (run_q > dl1_q)) status = status | STATUS_ANY | STATUS_T1;
    if (on2_q && (run_q > dl2_q)) status = status | STATUS_ANY | STATUS_T2;
  end

  assign rdata_o = (item_i.port == PORT_EXT_ADDR) ? STATUS_EXT : status;

endmodule
`default_nettype wire

// ===== rtl/core/fmtsp_checker.sv =====
`default_nettype none
module fmtsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] kind_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o
);
  import fmtsp_pkg::*;

  // stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(read_data_o))
    else $error("stalled result beat changed");

  // input backpressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // a fresh result follows an accepted read beat
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && kind_i == KIND_READ, 2))
    else $error("result without a read beat");

endmodule

bind fm_chip_timer_status_port_top fmtsp_checker u_fmtsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o)
);
`default_nettype wire

// ===== dv/fm_chip_timer_status_port_top_test.sv =====
module fm_chip_timer_status_port_top_test;
  import fmtsp_pkg::*;

  // full time base, as the block is built by default
  localparam int unsigned TIME_W        = 64;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 6;

  // codes the package leaves unnamed
  localparam logic [1:0]  KIND_NONE   = 2'd3;
  localparam logic [1:0]  PORT_NONE   = 2'd3;
  localparam logic [8:0]  EXT_BANK    = 9'h100;
  localparam logic [2:0]  ADDR_T1_PERIOD = {CFG_IDX_T1, 2'b00};
  localparam logic [2:0]  ADDR_T2_PERIOD = {CFG_IDX_T2, 2'b00};
  localparam logic [7:0]  CTRL_STOP  = 8'(1 << CTRL_STOP_BIT);
  localparam logic [7:0]  CTRL_MASK1 = 8'(1 << CTRL_MASK1_BIT);
  localparam logic [7:0]  CTRL_MASK2 = 8'(1 << CTRL_MASK2_BIT);
  localparam logic [7:0]  CTRL_ON1   = 8'(1 << CTRL_ON1_BIT);
  localparam logic [7:0]  CTRL_ON2   = 8'(1 << CTRL_ON2_BIT);
  localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;
  localparam logic [15:0] PERIOD_MIN  = 16'd1;
  localparam logic [15:0] PERIOD_MAX  = 16'hFFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic [1:0]  port_i;
  logic [7:0]  value_i;
  logic [19:0] elapsed_us_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fm_chip_timer_status_port_top #(
    .TIME_WIDTH(TIME_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .port_i       (port_i),
    .value_i      (value_i),
    .elapsed_us_i (elapsed_us_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // chip state as the testbench predicts it
  logic [TIME_W-1:0] now_us;
  logic [TIME_W-1:0] due_one;
  logic [TIME_W-1:0] due_two;
  logic [8:0]        reg_sel;
  logic [7:0]        preset_one;
  logic [7:0]        preset_two;
  logic              on_one;
  logic              on_two;
  logic [15:0]       period_one;
  logic [15:0]       period_two;

  // status bytes still owed by the block, oldest first
  logic [7:0]  want_q[$];
  logic [7:0]  want_byte;
  int unsigned errors;
  int unsigned cycles;
  bit          gaps_on;
  logic        beat_seen = 1'b0;
  logic [7:0]  beat_byte;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic flag_error(string msg);
    $display("ERROR [cycle %0d]: %s", cycles, msg);
    errors++;
  endtask

  // deadline of a timer started now
  function automatic logic [TIME_W-1:0] due_at(logic [7:0] preset, logic [15:0] period);
    logic [24:0] span;
    span = (COUNT_FULL - preset) * period;
    return now_us + span;
  endfunction

  // advance the predicted chip by one accepted item
  function automatic void chip_step(logic [1:0] k, logic [1:0] p, logic [7:0] v,
                                    logic [19:0] us);
    logic [7:0] status;
    case (k)
      KIND_TICK: now_us = now_us + us;
      KIND_WRITE: begin
        if (p == PORT_ADDR) reg_sel = {1'b0, v};
        else if (p == PORT_EXT_ADDR) reg_sel = {1'b1, v};
        else if (p == PORT_DATA) begin
          case (reg_sel)
            REG_PRESET_ONE: begin
              preset_one = v;
              if (on_one) due_one = due_at(preset_one, period_one);
            end
            REG_PRESET_TWO: begin
              preset_two = v;
              if (on_two) due_two = due_at(preset_two, period_two);
            end
            REG_CONTROL: begin
              if (v[CTRL_STOP_BIT]) begin
                on_one = 1'b0;
                on_two = 1'b0;
              end else begin
                if (!v[CTRL_MASK1_BIT]) begin
                  on_one = v[CTRL_ON1_BIT];
                  if (on_one) due_one = due_at(preset_one, period_one);
                end
                if (!v[CTRL_MASK2_BIT]) begin
                  on_two = v[CTRL_ON2_BIT];
                  if (on_two) due_two = due_at(preset_two, period_two);
                end
              end
            end
            default: ;
          endcase
        end
      end
      KIND_READ: begin
        status = '0;
        if (on_one && now_us > due_one) status |= STATUS_ANY | STATUS_T1;
        if (on_two && now_us > due_two) status |= STATUS_ANY | STATUS_T2;
        want_q.push_back((p == PORT_EXT_ADDR) ? STATUS_EXT : status);
      end
      default: ;
    endcase
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [19:0] draw_elapsed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 20'($urandom_range(0, 300));
    if (r < 80) return 20'($urandom_range(0, 5000));
    if (r < 95) return 20'($urandom_range(0, 100000));
    return 20'($urandom);
  endfunction

  // mostly the timer registers, some in the extended bank, a few anywhere
  function automatic logic [8:0] draw_reg();
    int unsigned r;
    logic [8:0]  num;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       num = REG_PRESET_ONE;
      1:       num = REG_PRESET_TWO;
      default: num = REG_CONTROL;
    endcase
    if (r >= 95) num = 9'($urandom);
    else if (r >= 85) num = num | EXT_BANK;
    return num;
  endfunction

  // presets lean high so deadlines come within reach of the ticks
  function automatic logic [7:0] draw_data(logic [8:0] num);
    if (num == REG_CONTROL) begin
      if ($urandom_range(0, 4) == 0) return CTRL_STOP | 8'($urandom);
      return ~CTRL_STOP & 8'($urandom);
    end
    if ($urandom_range(0, 9) < 6) return {4'hF, 4'($urandom)};
    return 8'($urandom);
  endfunction

  // one input beat, with an optional idle gap ahead of it
  task automatic send_op(logic [1:0] k, logic [1:0] p, logic [7:0] v, logic [19:0] us);
    int unsigned gap;
    bit          took;
    gap = gaps_on ? draw_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    port_i       <= p;
    value_i      <= v;
    elapsed_us_i <= us;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    chip_step(k, p, v, us);
  endtask

  task automatic tick(logic [19:0] us);
    send_op(KIND_TICK, 2'($urandom), 8'($urandom), us);
  endtask

  task automatic read_status(logic [1:0] p);
    send_op(KIND_READ, p, 8'($urandom), 20'($urandom));
  endtask

  // select a register, then write its data byte
  task automatic load_reg(logic [8:0] num, logic [7:0] data);
    send_op(KIND_WRITE, num[8] ? PORT_EXT_ADDR : PORT_ADDR, num[7:0], 20'($urandom));
    send_op(KIND_WRITE, PORT_DATA, data, 20'($urandom));
  endtask

  // hold the input until every owed status byte is back and the pipe is empty
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // period change, only with the block idle
  task automatic set_periods(logic [15:0] one_us, logic [15:0] two_us);
    drain_results();
    apb_write(ADDR_T1_PERIOD, {16'($urandom), one_us});
    period_one = one_us;
    apb_write(ADDR_T2_PERIOD, {16'($urandom), two_us});
    period_two = two_us;
  endtask

  // register sequences with random content, reads, ticks and some noise
  task automatic run_traffic(int unsigned n);
    int unsigned sent;
    int unsigned pick;
    logic [8:0]  num;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        read_status(($urandom_range(0, 9) < 7) ? PORT_ADDR : 2'($urandom));
        sent++;
      end else if (pick < 55) begin
        tick(draw_elapsed());
        sent++;
      end else if (pick < 90) begin
        num = draw_reg();
        load_reg(num, draw_data(num));
        sent += 2;
      end else begin
        case ($urandom_range(0, 3))
          0: send_op(KIND_NONE, 2'($urandom), 8'($urandom), 20'($urandom));
          1: send_op(KIND_WRITE, PORT_NONE, 8'($urandom), 20'($urandom));
          2: send_op(KIND_WRITE, PORT_DATA, 8'($urandom), 20'($urandom));
          default: send_op(KIND_WRITE, $urandom_range(0, 1) ? PORT_ADDR : PORT_EXT_ADDR,
                           8'($urandom), 20'($urandom));
        endcase
        sent++;
      end
    end
  endtask

  // status after reset on every port, unused kind and port
  task automatic test_idle_status();
    read_status(PORT_ADDR);
    read_status(PORT_DATA);
    read_status(PORT_EXT_ADDR);
    read_status(PORT_NONE);
    send_op(KIND_NONE, PORT_DATA, 8'hFF, ELAPSED_MAX);
    send_op(KIND_WRITE, PORT_NONE, 8'hFF, ELAPSED_MAX);
  endtask

  // expiry needs running time strictly past the deadline
  task automatic test_timer_one_boundary();
    load_reg(REG_PRESET_ONE, 8'hFF);
    load_reg(REG_CONTROL, CTRL_ON1);
    tick(20'(T1_PERIOD_RST));
    read_status(PORT_ADDR);
    tick(20'd1);
    read_status(PORT_ADDR);
  endtask

  // mask bit keeps timer one, extended bank control is ignored, stop clears
  task automatic test_timer_two_masks();
    load_reg(REG_PRESET_TWO, 8'h00);
    load_reg(REG_CONTROL, CTRL_MASK1 | CTRL_ON2);
    tick(ELAPSED_MAX);
    read_status(PORT_ADDR);
    load_reg(REG_CONTROL | EXT_BANK, CTRL_STOP);
    read_status(PORT_ADDR);
    load_reg(REG_CONTROL, CTRL_STOP);
    read_status(PORT_ADDR);
  endtask

  // random traffic under several period settings, extremes included
  task automatic test_period_sweep();
    run_traffic(140);
    set_periods(PERIOD_MIN, PERIOD_MIN);
    run_traffic(140);
    gaps_on = 1'b0;
    set_periods(PERIOD_MAX, PERIOD_MAX);
    run_traffic(120);
    gaps_on = 1'b1;
    set_periods(PERIOD_MIN, PERIOD_MAX);
    run_traffic(100);
    set_periods(16'($urandom_range(2, 600)), 16'($urandom_range(2, 2000)));
    run_traffic(100);
  endtask

  // longest deadlines, then full ticks walk up to them and past them
  task automatic test_far_deadline();
    set_periods(PERIOD_MAX, PERIOD_MAX);
    gaps_on = 1'b0;
    load_reg(REG_PRESET_ONE, 8'h00);
    load_reg(REG_PRESET_TWO, 8'h00);
    load_reg(REG_CONTROL, CTRL_ON1 | CTRL_ON2);
    read_status(PORT_ADDR);
    repeat (20) begin
      tick(ELAPSED_MAX);
      read_status(PORT_ADDR);
    end
    gaps_on = 1'b1;
    run_traffic(60);
  endtask

  // receiver stall: free stretches, short and occasional long holds
  initial begin : out_stall_gen
    int unsigned free_len;
    int unsigned hold_len;
    out_stall_i = 1'b0;
    forever begin
      free_len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 6);
      hold_len = draw_gap();
      repeat (free_len) @(posedge clk_i) out_stall_i <= 1'b0;
      repeat (hold_len) @(posedge clk_i) out_stall_i <= 1'b1;
    end
  end

  // sample the output beat away from the clock edge
  always @(negedge clk_i) begin
    beat_seen = rst_ni && out_valid_o && !out_stall_i;
    beat_byte = read_data_o;
  end

  // compare each beat with the oldest predicted status byte
  always @(posedge clk_i) begin
    if (beat_seen) begin
      if (want_q.size() == 0) begin
        flag_error($sformatf("read beat 0x%02h with nothing outstanding", beat_byte));
      end else begin
        want_byte = want_q.pop_front();
        if (beat_byte !== want_byte)
          flag_error($sformatf("read_data 0x%02h, predicted 0x%02h", beat_byte, want_byte));
      end
    end
  end

  // test sequence
  initial begin
    in_valid_i   = 1'b0;
    kind_i       = KIND_TICK;
    port_i       = PORT_ADDR;
    value_i      = '0;
    elapsed_us_i = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_ni       = 1'b0;
    gaps_on      = 1'b1;
    errors       = 0;
    cycles       = 0;
    now_us       = '0;
    due_one      = '0;
    due_two      = '0;
    reg_sel      = '0;
    preset_one   = '0;
    preset_two   = '0;
    on_one       = 1'b0;
    on_two       = 1'b0;
    period_one   = T1_PERIOD_RST;
    period_two   = T2_PERIOD_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_status();
    test_timer_one_boundary();
    test_timer_two_masks();
    test_period_sweep();
    test_far_deadline();
    drain_results();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fmtsp_pkg.sv
rtl/core/fmtsp_cfg.sv
rtl/core/fmtsp_core.sv
rtl/core/fm_chip_timer_status_port_top.sv
rtl/core/fmtsp_checker.sv
dv/fm_chip_timer_status_port_top_test.sv
